@@ src/rgbfb_pkg.sv @@
// Shared types, register indexes and pixel packing helpers for the
// RGB888 framebuffer packer. No dependencies.
`default_nettype none

package rgbfb_pkg;

  localparam int AddrW   = 28;
  localparam int CoordW  = 12;
  localparam int ColorW  = 32;
  localparam int PitchW  = 16;

  // Supported framebuffer depths
  localparam logic [5:0] DEPTH_15 = 6'd15;
  localparam logic [5:0] DEPTH_16 = 6'd16;
  localparam logic [5:0] DEPTH_24 = 6'd24;
  localparam logic [5:0] DEPTH_32 = 6'd32;

  typedef enum logic [2:0] {
    REG_RED_POS    = 3'd0,
    REG_RED_SIZE   = 3'd1,
    REG_GREEN_POS  = 3'd2,
    REG_GREEN_SIZE = 3'd3,
    REG_BLUE_POS   = 3'd4,
    REG_BLUE_SIZE  = 3'd5,
    REG_DEPTH      = 3'd6,
    REG_PITCH      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]        red_shift;
    logic [3:0]        red_size;
    logic [4:0]        green_shift;
    logic [3:0]        green_size;
    logic [4:0]        blue_shift;
    logic [3:0]        blue_size;
    logic [5:0]        depth;
    logic [PitchW-1:0] pitch;
  } cfg_t;

  // One packed pixel on its way to the byte serializer
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [31:0]      word;
    logic [2:0]       nbytes;
  } pix_t;

  // Bytes written per pixel; zero for a depth that produces no writes.
  function automatic logic [2:0] depth_bytes(input logic [5:0] depth);
    logic [2:0] n;
    case (depth)
      DEPTH_15: n = 3'd2;
      DEPTH_16: n = 3'd2;
      DEPTH_24: n = 3'd3;
      DEPTH_32: n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // Keep the top 'size' bits of a channel (sizes above eight act as eight)
  // and place them at 'pos'; bits past bit 31 fall off.
  function automatic logic [31:0] place_channel(input logic [7:0] chan,
                                                input logic [3:0] size,
                                                input logic [4:0] pos);
    logic [3:0]  n;
    logic [7:0]  kept;
    n    = (size > 4'd8) ? 4'd8 : size;
    kept = chan >> (4'd8 - n);
    return {24'd0, kept} << pos;
  endfunction

endpackage

`default_nettype wire

@@ src/rgb888_to_framebuffer_packer.sv @@
// Top level of the RGB888 framebuffer packer: configuration registers,
// pack stage and byte serializer. Depends on rgbfb_pkg, rgbfb_pack, rgbfb_serial.
`default_nettype none

// Converts one 0x00RRGGBB pixel with its column and row into little-endian
// byte writes for a linear framebuffer. Each channel keeps its top <size>
// bits (sizes above eight act as eight) and lands at its <position> in a
// 32-bit word; the byte address is row*pitch + column*bytes_per_pixel,
// wrapped to 28 bits. Depth 15/16 gives 2 writes, 24 gives 3, 32 gives 4;
// any other depth, or a pixel outside MAX_WIDTH x MAX_HEIGHT, gives none.
// Rate: one byte write per cycle on the output channel while out_tready is
// high; the one-byte output channel limits the pixel rate. A pixel that
// yields no writes is dropped without waiting on the serializer. From input
// accept to the first byte, the pixel passes the input register, then the
// serializer register. The input stage takes the next pixel while the
// serializer is still emitting the previous one. Write configuration only
// while the block is idle; cfg_ready is always high.

module rgb888_to_framebuffer_packer #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: column [11:0], row [23:12], pixel_color [55:24]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,
  // out_tdata: byte_address [27:0], byte_value [35:28], zero pad [39:36]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,
  output logic             out_tlast,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import rgbfb_pkg::*;

  cfg_t             cfg_r;
  logic             pix_valid;
  logic             pix_ready;
  pix_t             pix;
  logic [AddrW-1:0] out_address;
  logic [7:0]       out_value;

  assign cfg_ready = 1'b1;

  // Register file: keep only the low bits each register holds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_shift   <= 5'd16;
      cfg_r.red_size    <= 4'd8;
      cfg_r.green_shift <= 5'd8;
      cfg_r.green_size  <= 4'd8;
      cfg_r.blue_shift  <= 5'd0;
      cfg_r.blue_size   <= 4'd8;
      cfg_r.depth       <= DEPTH_32;
      cfg_r.pitch       <= 16'd4096;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_RED_POS:    cfg_r.red_shift   <= cfg_data[4:0];
        REG_RED_SIZE:   cfg_r.red_size    <= cfg_data[3:0];
        REG_GREEN_POS:  cfg_r.green_shift <= cfg_data[4:0];
        REG_GREEN_SIZE: cfg_r.green_size  <= cfg_data[3:0];
        REG_BLUE_POS:   cfg_r.blue_shift  <= cfg_data[4:0];
        REG_BLUE_SIZE:  cfg_r.blue_size   <= cfg_data[3:0];
        REG_DEPTH:      cfg_r.depth       <= cfg_data[5:0];
        REG_PITCH:      cfg_r.pitch       <= cfg_data;
        default: ;
      endcase
    end
  end

  rgbfb_pack #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_column (in_tdata[11:0]),
    .in_row    (in_tdata[23:12]),
    .in_color  (in_tdata[55:24]),
    .cfg       (cfg_r),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  rgbfb_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix         (pix),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_address (out_address),
    .out_value   (out_value),
    .out_last    (out_tlast)
  );

  assign out_tdata = {4'd0, out_value, out_address};

endmodule

`default_nettype wire

@@ src/rgbfb_pack.sv @@
// Input register stage: packs the color word and computes the byte address.
// Depends on rgbfb_pkg.
`default_nettype none

module rgbfb_pack #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rgbfb_pkg::CoordW-1:0] in_column,
  input  wire logic [rgbfb_pkg::CoordW-1:0] in_row,
  input  wire logic [rgbfb_pkg::ColorW-1:0] in_color,
  input  wire rgbfb_pkg::cfg_t             cfg,
  output logic                             pix_valid,
  input  wire logic                        pix_ready,
  output rgbfb_pkg::pix_t                  pix
);
  import rgbfb_pkg::*;

  localparam logic [16:0] LimW = 17'(MAX_WIDTH);
  localparam logic [16:0] LimH = 17'(MAX_HEIGHT);

  logic              a_valid_r, a_valid_nxt;
  logic [CoordW-1:0] a_col_r;
  logic [CoordW-1:0] a_row_r;
  logic [ColorW-1:0] a_color_r;

  logic [2:0]        nbytes;
  logic              in_frame;
  logic              keep;
  logic              advance;
  logic [AddrW-1:0]  row_off;
  logic [13:0]       col_off;
  logic [31:0]       word;

  assign nbytes   = depth_bytes(cfg.depth);
  assign in_frame = ({5'd0, a_col_r} < LimW) && ({5'd0, a_row_r} < LimH);
  assign keep     = (nbytes != 3'd0) && in_frame;

  // Drop items that produce no writes without waiting on the serializer
  assign advance   = !a_valid_r || !keep || pix_ready;
  assign in_ready  = advance;
  assign pix_valid = a_valid_r && keep;

  assign row_off = {{(AddrW-CoordW){1'b0}}, a_row_r} * {{(AddrW-PitchW){1'b0}}, cfg.pitch};

  always_comb begin
    case (nbytes)
      3'd2:    col_off = {1'b0, a_col_r, 1'b0};
      3'd3:    col_off = {2'b00, a_col_r} + {1'b0, a_col_r, 1'b0};
      3'd4:    col_off = {a_col_r, 2'b00};
      default: col_off = '0;
    endcase
  end

  assign word = place_channel(a_color_r[23:16], cfg.red_size, cfg.red_shift)
              | place_channel(a_color_r[15:8], cfg.green_size, cfg.green_shift)
              | place_channel(a_color_r[7:0], cfg.blue_size, cfg.blue_shift);

  assign pix.addr   = row_off + {{(AddrW-14){1'b0}}, col_off};
  assign pix.word   = word;
  assign pix.nbytes = nbytes;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (advance) begin
      a_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      a_col_r   <= in_column;
      a_row_r   <= in_row;
      a_color_r <= in_color;
    end
  end

endmodule

`default_nettype wire

@@ src/rgbfb_serial.sv @@
// Byte serializer: holds one packed pixel and emits its bytes, low first.
// Depends on rgbfb_pkg.
`default_nettype none

module rgbfb_serial (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        pix_valid,
  output logic                             pix_ready,
  input  wire rgbfb_pkg::pix_t             pix,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rgbfb_pkg::AddrW-1:0]      out_address,
  output logic [7:0]                       out_value,
  output logic                             out_last
);
  import rgbfb_pkg::*;

  logic             b_valid_r, b_valid_nxt;
  logic [31:0]      b_word_r;
  logic [AddrW-1:0] b_addr_r;
  logic [2:0]       b_left_r;
  logic             last;
  logic             take;

  assign last        = (b_left_r == 3'd1);
  assign pix_ready   = !b_valid_r || (out_ready && last);
  assign take        = pix_valid && pix_ready;
  assign out_valid   = b_valid_r;
  assign out_address = b_addr_r;
  assign out_value   = b_word_r[7:0];
  assign out_last    = last;

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (take) begin
      b_valid_nxt = 1'b1;
    end else if (b_valid_r && out_ready && last) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_word_r <= pix.word;
      b_addr_r <= pix.addr;
      b_left_r <= pix.nbytes;
    end else if (b_valid_r && out_ready && !last) begin
      // advance to the next byte of the same pixel
      b_word_r <= {8'd0, b_word_r[31:8]};
      b_addr_r <= b_addr_r + {{(AddrW-1){1'b0}}, 1'b1};
      b_left_r <= b_left_r - 3'd1;
    end
  end

endmodule

`default_nettype wire

@@ src/rgbfb_checker.sv @@
// Port-level checker for the RGB888 framebuffer packer, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none

module rgbfb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Bytes of one pixel go to consecutive addresses
  a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[27:0] == 28'($past(out_tdata[27:0]) + 28'd1)))
    else $error("byte address did not advance within a pixel");

  // Drop output valid after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind rgb888_to_framebuffer_packer rgbfb_checker u_rgbfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire
